FILE: rtl/packet_rule_classifier_core_defines.svh
// Assertion shorthands for the classifier core.
`ifndef PACKET_RULE_CLASSIFIER_CORE_DEFINES_SVH
`define PACKET_RULE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prc check failed");

// next-cycle implication, checked outside reset
`define PRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prc check failed");

`endif

FILE: rtl/prc_pkg.sv
package prc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SECONDS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SECONDS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_MODE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENDPOINT_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_COUNT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_COUNT     = 3'd5;

    // operations
    localparam logic [1:0] OP_CLASSIFY    = 2'd0;
    localparam logic [1:0] OP_WR_ENDPOINT = 2'd1;
    localparam logic [1:0] OP_WR_ADDRESS  = 2'd2;
    localparam logic [1:0] OP_WR_PORT     = 2'd3;

    // match causes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_TIME     = 3'd1;
    localparam logic [2:0] CAUSE_CONTENT  = 3'd2;
    localparam logic [2:0] CAUSE_ENDPOINT = 3'd3;
    localparam logic [2:0] CAUSE_ADDRESS  = 3'd4;
    localparam logic [2:0] CAUSE_PORT     = 3'd5;
    localparam logic [2:0] CAUSE_PROTOCOL = 3'd6;

    // rule_mode bit positions
    localparam int MODE_CONTENT  = 0;
    localparam int MODE_EPLIST   = 1;
    localparam int MODE_IPLIST   = 2;
    localparam int MODE_PORTLIST = 3;
    localparam int MODE_BOTHEP   = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  table_slot;
        logic [31:0] entry_address;
        logic [15:0] entry_port;
        logic [31:0] packet_seconds;
        logic [31:0] src_address;
        logic [15:0] src_port;
        logic [31:0] dst_address;
        logic [15:0] dst_port;
        logic [5:0]  packet_class;
    } prc_in_t;

    typedef struct packed {
        logic       matched;
        logic [2:0] match_cause;
    } prc_out_t;

    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic resolve;
        logic publish;
    } prc_cmd_t;

    typedef struct packed {
        logic early_done;
        logic scan_done;
    } prc_status_t;

endpackage

FILE: rtl/packet_rule_classifier_core.sv
// Writes and items decided without a lookup skip the table scan; lookups scan the tables
// up to N entries (N the largest enabled clamped count).
// One item at a time: the next transfer can be taken in the cycle in which out_valid
// rises; the scan reads one entry per table per cycle.
// Reset (rst_n, async, active low) clears the control state and all configuration
// registers; table contents are not cleared and must be written before use.
module packet_rule_classifier_core #(
    parameter int ENDPOINT_ENTRIES = 16,
    parameter int ADDRESS_ENTRIES  = 16,
    parameter int PORT_ENTRIES     = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  prc_pkg::prc_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output prc_pkg::prc_out_t               out_data,
    input  logic                            cfg_write_en,
    input  logic [prc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import prc_pkg::*;

    `include "packet_rule_classifier_core_defines.svh"

    prc_cmd_t    cmd;
    prc_status_t status;

    prc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    prc_datapath #(
        .ENDPOINT_ENTRIES (ENDPOINT_ENTRIES),
        .ADDRESS_ENTRIES  (ADDRESS_ENTRIES),
        .PORT_ENTRIES     (PORT_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status)
    );

    // a transfer in makes the block busy until its result is published
    `PRC_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
    // a fresh result arrives together with the block going idle
    `PRC_ASSERT_NOW(a_result_frees_input, $rose(out_valid), !in_stall)
    // matched agrees with the cause code
    `PRC_ASSERT_NOW(a_matched_cause, out_valid, out_data.matched == (out_data.match_cause >= CAUSE_CONTENT))
    `PRC_ASSERT_NOW(a_cause_range, out_valid, out_data.match_cause <= CAUSE_PROTOCOL)

endmodule

FILE: rtl/prc_ctrl.sv
module prc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  prc_pkg::prc_status_t status,
    output prc_pkg::prc_cmd_t    cmd
);
    import prc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_publish;

    assign can_publish = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        in_stall_next  = in_stall_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    state_next    = S_CHECK;
                    in_stall_next = 1'b1;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.early_done ? S_FINAL : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = S_FINAL;
                end
            end
            S_FINAL:
            begin
                // result register frees when the pending transfer completes
                if (can_publish)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    in_stall_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= in_stall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/prc_datapath.sv
module prc_datapath #(
    parameter int ENDPOINT_ENTRIES = 16,
    parameter int ADDRESS_ENTRIES  = 16,
    parameter int PORT_ENTRIES     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  prc_pkg::prc_in_t                    in_data,
    output prc_pkg::prc_out_t                   out_data,
    input  logic                                cfg_write_en,
    input  logic [prc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  prc_pkg::prc_cmd_t                   cmd,
    output prc_pkg::prc_status_t                status
);
    import prc_pkg::*;

    localparam int EP_AW   = (ENDPOINT_ENTRIES > 1) ? $clog2(ENDPOINT_ENTRIES) : 1;
    localparam int IP_AW   = (ADDRESS_ENTRIES > 1) ? $clog2(ADDRESS_ENTRIES) : 1;
    localparam int PT_AW   = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int MAX_A   = (ENDPOINT_ENTRIES > ADDRESS_ENTRIES) ?
                             ENDPOINT_ENTRIES : ADDRESS_ENTRIES;
    localparam int MAX_DEPTH = (MAX_A > PORT_ENTRIES) ? MAX_A : PORT_ENTRIES;
    localparam int LIM_W   = $clog2(MAX_DEPTH + 1);

    // configuration
    logic [31:0] min_seconds_reg;
    logic [31:0] max_seconds_reg;
    logic [9:0]  rule_mode_reg;
    logic [4:0]  ep_count_reg;
    logic [4:0]  ip_count_reg;
    logic [4:0]  pt_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_seconds_reg <= '0;
            max_seconds_reg <= '0;
            rule_mode_reg   <= '0;
            ep_count_reg    <= '0;
            ip_count_reg    <= '0;
            pt_count_reg    <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MIN_SECONDS:    min_seconds_reg <= cfg_data;
                CFG_MAX_SECONDS:    max_seconds_reg <= cfg_data;
                CFG_RULE_MODE:      rule_mode_reg   <= cfg_data[9:0];
                CFG_ENDPOINT_COUNT: ep_count_reg    <= cfg_data[4:0];
                CFG_ADDRESS_COUNT:  ip_count_reg    <= cfg_data[4:0];
                CFG_PORT_COUNT:     pt_count_reg    <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // captured item
    prc_in_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    logic [47:0] src_key, dst_key;
    logic        mode_ep, mode_ip, mode_pt, any_list;
    assign src_key  = {item_reg.src_address, item_reg.src_port};
    assign dst_key  = {item_reg.dst_address, item_reg.dst_port};
    assign mode_ep  = rule_mode_reg[MODE_EPLIST];
    assign mode_ip  = rule_mode_reg[MODE_IPLIST];
    assign mode_pt  = rule_mode_reg[MODE_PORTLIST];
    assign any_list = rule_mode_reg[MODE_CONTENT] | mode_ep | mode_ip | mode_pt;

    // clamped table fill levels
    logic [LIM_W-1:0] n_ep, n_ip, n_pt, limit;

    always_comb
    begin
        n_ep = (32'(ep_count_reg) > 32'(ENDPOINT_ENTRIES)) ?
               LIM_W'(ENDPOINT_ENTRIES) : LIM_W'(ep_count_reg);
        n_ip = (32'(ip_count_reg) > 32'(ADDRESS_ENTRIES)) ?
               LIM_W'(ADDRESS_ENTRIES) : LIM_W'(ip_count_reg);
        n_pt = (32'(pt_count_reg) > 32'(PORT_ENTRIES)) ?
               LIM_W'(PORT_ENTRIES) : LIM_W'(pt_count_reg);
        limit = '0;
        if (mode_ep)
        begin
            limit = n_ep;
        end
        if (mode_ip && (n_ip > limit))
        begin
            limit = n_ip;
        end
        if (mode_pt && (n_pt > limit))
        begin
            limit = n_pt;
        end
    end

    // first-pass decision: writes, time window, protocol mode, content
    logic       is_write, time_reject, content_hit, early_done;
    logic [2:0] early_cause;

    always_comb
    begin
        is_write    = (item_reg.operation != OP_CLASSIFY);
        time_reject = ((min_seconds_reg != '0) && (min_seconds_reg > item_reg.packet_seconds)) ||
                      ((max_seconds_reg != '0) && (max_seconds_reg < item_reg.packet_seconds));
        content_hit = rule_mode_reg[MODE_CONTENT] && item_reg.packet_class[0];
        early_done  = is_write || time_reject || !any_list || content_hit;
        if (is_write)
        begin
            early_cause = CAUSE_NONE;
        end
        else if (time_reject)
        begin
            early_cause = CAUSE_TIME;
        end
        else if (!any_list)
        begin
            early_cause = ((rule_mode_reg[9:5] & item_reg.packet_class[5:1]) != '0) ?
                          CAUSE_PROTOCOL : CAUSE_NONE;
        end
        else if (content_hit)
        begin
            early_cause = CAUSE_CONTENT;
        end
        else
        begin
            early_cause = CAUSE_NONE;
        end
    end

    // table writes
    logic ep_we, ip_we, pt_we;
    assign ep_we = cmd.check && (item_reg.operation == OP_WR_ENDPOINT) &&
                   (32'(item_reg.table_slot) < 32'(ENDPOINT_ENTRIES));
    assign ip_we = cmd.check && (item_reg.operation == OP_WR_ADDRESS) &&
                   (32'(item_reg.table_slot) < 32'(ADDRESS_ENTRIES));
    assign pt_we = cmd.check && (item_reg.operation == OP_WR_PORT) &&
                   (32'(item_reg.table_slot) < 32'(PORT_ENTRIES));

    // scan pointer and table memories
    logic [LIM_W-1:0] idx_reg;
    logic             issue;
    logic [47:0]      ep_mem [ENDPOINT_ENTRIES];
    logic [31:0]      ip_mem [ADDRESS_ENTRIES];
    logic [15:0]      pt_mem [PORT_ENTRIES];
    logic [47:0]      ep_rd_reg;
    logic [31:0]      ip_rd_reg;
    logic [15:0]      pt_rd_reg;

    assign issue = idx_reg < limit;

    always_ff @(posedge clk)
    begin
        if (ep_we)
        begin
            ep_mem[EP_AW'(item_reg.table_slot)] <= {item_reg.entry_address, item_reg.entry_port};
        end
        ep_rd_reg <= ep_mem[idx_reg[EP_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            ip_mem[IP_AW'(item_reg.table_slot)] <= item_reg.entry_address;
        end
        ip_rd_reg <= ip_mem[idx_reg[IP_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[PT_AW'(item_reg.table_slot)] <= item_reg.entry_port;
        end
        pt_rd_reg <= pt_mem[idx_reg[PT_AW-1:0]];
    end

    // read-data valid flags and sticky hits
    logic ep_rv_reg, ip_rv_reg, pt_rv_reg;
    logic ep_src_hit_reg, ep_dst_hit_reg, ip_hit_reg, pt_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            ep_rv_reg      <= 1'b0;
            ip_rv_reg      <= 1'b0;
            pt_rv_reg      <= 1'b0;
            ep_src_hit_reg <= 1'b0;
            ep_dst_hit_reg <= 1'b0;
            ip_hit_reg     <= 1'b0;
            pt_hit_reg     <= 1'b0;
        end
        else if (cmd.check)
        begin
            idx_reg        <= '0;
            ep_rv_reg      <= 1'b0;
            ip_rv_reg      <= 1'b0;
            pt_rv_reg      <= 1'b0;
            ep_src_hit_reg <= 1'b0;
            ep_dst_hit_reg <= 1'b0;
            ip_hit_reg     <= 1'b0;
            pt_hit_reg     <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            ep_rv_reg <= issue && mode_ep && (idx_reg < n_ep);
            ip_rv_reg <= issue && mode_ip && (idx_reg < n_ip);
            pt_rv_reg <= issue && mode_pt && (idx_reg < n_pt);
            if (ep_rv_reg && (ep_rd_reg == src_key))
            begin
                ep_src_hit_reg <= 1'b1;
            end
            if (ep_rv_reg && (ep_rd_reg == dst_key))
            begin
                ep_dst_hit_reg <= 1'b1;
            end
            if (ip_rv_reg && ((ip_rd_reg == item_reg.src_address) ||
                              (ip_rd_reg == item_reg.dst_address)))
            begin
                ip_hit_reg <= 1'b1;
            end
            if (pt_rv_reg && ((pt_rd_reg == item_reg.src_port) ||
                              (pt_rd_reg == item_reg.dst_port)))
            begin
                pt_hit_reg <= 1'b1;
            end
        end
    end

    logic scan_done;
    assign scan_done = !issue && !ep_rv_reg && !ip_rv_reg && !pt_rv_reg;

    assign status = '{early_done: early_done, scan_done: scan_done};

    // final decision after the scan, priority endpoint, address, port
    logic       ep_match;
    logic [2:0] scan_cause;

    always_comb
    begin
        ep_match = rule_mode_reg[MODE_BOTHEP] ? (ep_src_hit_reg && ep_dst_hit_reg) :
                                                (ep_src_hit_reg || ep_dst_hit_reg);
        if (mode_ep && ep_match)
        begin
            scan_cause = CAUSE_ENDPOINT;
        end
        else if (ip_hit_reg)
        begin
            scan_cause = CAUSE_ADDRESS;
        end
        else if (pt_hit_reg)
        begin
            scan_cause = CAUSE_PORT;
        end
        else
        begin
            scan_cause = CAUSE_NONE;
        end
    end

    logic [2:0] cause_reg;
    prc_out_t   out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            cause_reg <= early_cause;
        end
        else if (cmd.resolve)
        begin
            cause_reg <= scan_cause;
        end
        if (cmd.publish)
        begin
            out_reg.matched     <= (cause_reg >= CAUSE_CONTENT);
            out_reg.match_cause <= cause_reg;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: verif/prc_verdict_checker.sv
`timescale 1ns / 1ps

module prc_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  prc_pkg::prc_in_t                in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  prc_pkg::prc_out_t               out_data,
    input  logic                            cfg_write_en,
    input  logic [prc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              error_count,
    output int                              outstanding
);
    import prc_pkg::*;

    localparam int ENDPOINT_DEPTH = 16;
    localparam int ADDRESS_DEPTH  = 16;
    localparam int PORT_DEPTH     = 16;
    localparam int REPORT_LIMIT   = 10;

    logic [31:0] lo_seconds;
    logic [31:0] hi_seconds;
    logic [9:0]  rule_bits;
    logic [4:0]  endpoint_cnt;
    logic [4:0]  address_cnt;
    logic [4:0]  port_cnt;

    logic [47:0] endpoint_tbl [ENDPOINT_DEPTH];
    logic [31:0] address_tbl  [ADDRESS_DEPTH];
    logic [15:0] port_tbl     [PORT_DEPTH];

    prc_out_t verdict_q [$];
    int       errors = 0;

    function automatic int clamp_depth(logic [4:0] cnt, int depth);
        return (int'(cnt) > depth) ? depth : int'(cnt);
    endfunction

    function automatic logic [2:0] classify_cause(prc_in_t pkt);
        logic [47:0] src_key;
        logic [47:0] dst_key;
        logic        src_hit;
        logic        dst_hit;
        int          n;
        if ((lo_seconds != 0 && lo_seconds > pkt.packet_seconds) ||
            (hi_seconds != 0 && hi_seconds < pkt.packet_seconds))
            return CAUSE_TIME;

        // no list enabled: rule bits 9..5 line up with class bits 5..1
        if (rule_bits[3:0] == 4'b0)
            return ((rule_bits[9:5] & pkt.packet_class[5:1]) != 5'b0) ? CAUSE_PROTOCOL
                                                                      : CAUSE_NONE;

        if (rule_bits[MODE_CONTENT] && pkt.packet_class[0])
            return CAUSE_CONTENT;

        if (rule_bits[MODE_EPLIST]) begin
            src_key = {pkt.src_address, pkt.src_port};
            dst_key = {pkt.dst_address, pkt.dst_port};
            src_hit = 1'b0;
            dst_hit = 1'b0;
            n = clamp_depth(endpoint_cnt, ENDPOINT_DEPTH);
            for (int i = 0; i < n; i++) begin
                if (endpoint_tbl[i] == src_key) src_hit = 1'b1;
                if (endpoint_tbl[i] == dst_key) dst_hit = 1'b1;
            end
            if (rule_bits[MODE_BOTHEP] ? (src_hit && dst_hit) : (src_hit || dst_hit))
                return CAUSE_ENDPOINT;
        end

        if (rule_bits[MODE_IPLIST]) begin
            n = clamp_depth(address_cnt, ADDRESS_DEPTH);
            for (int i = 0; i < n; i++)
                if (address_tbl[i] == pkt.src_address || address_tbl[i] == pkt.dst_address)
                    return CAUSE_ADDRESS;
        end

        if (rule_bits[MODE_PORTLIST]) begin
            n = clamp_depth(port_cnt, PORT_DEPTH);
            for (int i = 0; i < n; i++)
                if (port_tbl[i] == pkt.src_port || port_tbl[i] == pkt.dst_port)
                    return CAUSE_PORT;
        end

        return CAUSE_NONE;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        prc_out_t want;
        logic [2:0] cause;
        if (!rst_n) begin
            lo_seconds   = '0;
            hi_seconds   = '0;
            rule_bits    = '0;
            endpoint_cnt = '0;
            address_cnt  = '0;
            port_cnt     = '0;
            for (int i = 0; i < ENDPOINT_DEPTH; i++) endpoint_tbl[i] = '0;
            for (int i = 0; i < ADDRESS_DEPTH; i++) address_tbl[i] = '0;
            for (int i = 0; i < PORT_DEPTH; i++) port_tbl[i] = '0;
            verdict_q.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: unexpected transfer, matched=%0b cause=%0d",
                                 $time, out_data.matched, out_data.match_cause);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_data.matched !== want.matched ||
                        out_data.match_cause !== want.match_cause) begin
                        if (errors < REPORT_LIMIT)
                            $display("%0t: verdict mismatch, expected matched=%0b cause=%0d, got matched=%0b cause=%0d",
                                     $time, want.matched, want.match_cause,
                                     out_data.matched, out_data.match_cause);
                        errors++;
                    end
                end
            end

            if (cfg_write_en) begin
                case (cfg_index)
                    CFG_MIN_SECONDS:    lo_seconds   = cfg_data;
                    CFG_MAX_SECONDS:    hi_seconds   = cfg_data;
                    CFG_RULE_MODE:      rule_bits    = cfg_data[9:0];
                    CFG_ENDPOINT_COUNT: endpoint_cnt = cfg_data[4:0];
                    CFG_ADDRESS_COUNT:  address_cnt  = cfg_data[4:0];
                    CFG_PORT_COUNT:     port_cnt     = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall) begin
                cause = CAUSE_NONE;
                case (in_data.operation)
                    OP_CLASSIFY:
                        cause = classify_cause(in_data);
                    OP_WR_ENDPOINT:
                        endpoint_tbl[in_data.table_slot] = {in_data.entry_address,
                                                            in_data.entry_port};
                    OP_WR_ADDRESS:
                        address_tbl[in_data.table_slot] = in_data.entry_address;
                    default:
                        port_tbl[in_data.table_slot] = in_data.entry_port;
                endcase
                want.matched     = (cause >= CAUSE_CONTENT);
                want.match_cause = cause;
                verdict_q.push_back(want);
            end
        end
        error_count <= errors;
        outstanding <= verdict_q.size();
    end

endmodule

FILE: verif/tb_packet_rule_classifier_core.sv
`timescale 1ns / 1ps

module tb_packet_rule_classifier_core;
    import prc_pkg::*;

    localparam int SLOTS           = 16;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 130;

    localparam logic [9:0]  MODE_PROTOCOLS = 10'b11111_00000;
    localparam logic [9:0]  MODE_ALL_LISTS = 10'b00000_01111;
    localparam logic [5:0]  CLASS_CONTENT  = 6'b000001;
    localparam logic [47:0] EP_WEB         = {32'hC0A8_0001, 16'd443};
    localparam logic [47:0] EP_MDNS        = {32'h0A00_0002, 16'd5353};

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    prc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    prc_out_t out_data;
    logic     cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int verdict_errors;
    int verdicts_owed;
    int tx_idle_pct = 21;
    int rx_stall_pct = 21;
    int hold_cycles = 0;

    // sender-side copy of the tables, only used to aim packets at entries
    logic [47:0] ep_shadow   [SLOTS];
    logic [31:0] addr_shadow [SLOTS];
    logic [15:0] port_shadow [SLOTS];
    logic [31:0] lo_bound;
    logic [31:0] hi_bound;

    packet_rule_classifier_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    prc_verdict_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (verdict_errors),
        .outstanding  (verdicts_owed)
    );

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_half();
        case ($urandom_range(5))
            0:       return 16'h0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_seconds();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return lo_bound - 32'd1;
            3:       return lo_bound;
            4:       return hi_bound;
            5:       return hi_bound + 32'd1;
            6, 7:    return lo_bound + ((hi_bound - lo_bound) >> 1);
            default: return $urandom;
        endcase
    endfunction

    // mostly endpoints that sit in one of the tables, so lookups hit
    function automatic logic [47:0] pick_endpoint();
        case ($urandom_range(9))
            0, 1, 2: return ep_shadow[$urandom_range(SLOTS-1)];
            3, 4:    return {addr_shadow[$urandom_range(SLOTS-1)], pick_half()};
            5, 6:    return {pick_word(), port_shadow[$urandom_range(SLOTS-1)]};
            default: return {pick_word(), pick_half()};
        endcase
    endfunction

    function automatic prc_in_t random_item();
        prc_in_t it;
        it.operation      = OP_CLASSIFY;
        it.table_slot     = 4'($urandom);
        it.entry_address  = pick_word();
        it.entry_port     = pick_half();
        if ($urandom_range(99) < 25)
            it.operation = 2'($urandom_range(3, 1));
        it.packet_seconds = pick_seconds();
        {it.src_address, it.src_port} = pick_endpoint();
        {it.dst_address, it.dst_port} = pick_endpoint();
        it.packet_class   = 6'($urandom);
        return it;
    endfunction

    function automatic prc_in_t header(logic [31:0] sec, logic [47:0] src, logic [47:0] dst,
                                       logic [5:0] cls);
        prc_in_t it;
        it = '0;
        it.operation      = OP_CLASSIFY;
        it.packet_seconds = sec;
        {it.src_address, it.src_port} = src;
        {it.dst_address, it.dst_port} = dst;
        it.packet_class   = cls;
        return it;
    endfunction

    function automatic prc_in_t table_write(logic [1:0] op, logic [3:0] slot,
                                            logic [31:0] addr, logic [15:0] port);
        prc_in_t it;
        it = '0;
        it.operation     = op;
        it.table_slot    = slot;
        it.entry_address = addr;
        it.entry_port    = port;
        return it;
    endfunction

    // call right after a rising edge; returns at the edge of the transfer
    task automatic offer(prc_in_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        case (it.operation)
            OP_WR_ENDPOINT: ep_shadow[it.table_slot]   = {it.entry_address, it.entry_port};
            OP_WR_ADDRESS:  addr_shadow[it.table_slot] = it.entry_address;
            OP_WR_PORT:     port_shadow[it.table_slot] = it.entry_port;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
    endtask

    task automatic apply_rule(logic [31:0] lo, logic [31:0] hi, logic [9:0] mode,
                              logic [4:0] ep_n, logic [4:0] addr_n, logic [4:0] port_n);
        drain();
        set_reg(CFG_MIN_SECONDS, lo);
        set_reg(CFG_MAX_SECONDS, hi);
        set_reg(CFG_RULE_MODE, 32'(mode));
        set_reg(CFG_ENDPOINT_COUNT, 32'(ep_n));
        set_reg(CFG_ADDRESS_COUNT, 32'(addr_n));
        set_reg(CFG_PORT_COUNT, 32'(port_n));
        cfg_write_en <= 1'b0;
        lo_bound = lo;
        hi_bound = hi;
    endtask

    function automatic logic [4:0] pick_count();
        case ($urandom_range(5))
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'd31;
            default: return 5'($urandom_range(16, 1));
        endcase
    endfunction

    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [9:0]  mode;
        logic [4:0]  ep_n;
        logic [4:0]  addr_n;
        logic [4:0]  port_n;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        lo_bound     = '0;
        hi_bound     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            ep_shadow[i]   = '0;
            addr_shadow[i] = '0;
            port_shadow[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // time window edges and the protocol path; counts stay zero until tables load
        offer(header(32'd5, EP_WEB, EP_MDNS, 6'h3F));
        apply_rule(32'd100, 32'd200, MODE_PROTOCOLS, 5'd0, 5'd0, 5'd0);
        offer(header(32'd99, EP_WEB, EP_MDNS, 6'h3E));
        offer(header(32'd100, EP_WEB, EP_MDNS, 6'h3E));
        offer(header(32'd200, EP_WEB, EP_MDNS, 6'h20));
        offer(header(32'd201, EP_WEB, EP_MDNS, 6'h3E));
        offer(header(32'h0, EP_WEB, EP_MDNS, 6'h3E));
        offer(header(32'hFFFF_FFFF, EP_WEB, EP_MDNS, 6'h3E));
        offer(header(32'd150, EP_WEB, EP_MDNS, CLASS_CONTENT));
        apply_rule(32'd0, 32'd0, 10'b00001_00000, 5'd0, 5'd0, 5'd0);
        offer(header(32'd7, EP_WEB, EP_MDNS, 6'h02));
        offer(header(32'd7, EP_WEB, EP_MDNS, 6'h3C));

        // fill every slot before any count lets a lookup read it
        for (int s = 0; s < SLOTS; s++) begin
            offer(table_write(OP_WR_ENDPOINT, 4'(s), pick_word(), pick_half()));
            offer(table_write(OP_WR_ADDRESS, 4'(s), pick_word(), pick_half()));
            offer(table_write(OP_WR_PORT, 4'(s), pick_word(), pick_half()));
        end
        offer(table_write(OP_WR_ENDPOINT, 4'd0, EP_WEB[47:16], EP_WEB[15:0]));
        offer(table_write(OP_WR_ENDPOINT, 4'd15, EP_MDNS[47:16], EP_MDNS[15:0]));
        offer(table_write(OP_WR_ADDRESS, 4'd15, 32'hFFFF_FFFF, 16'h0));
        offer(table_write(OP_WR_PORT, 4'd15, 32'h0, 16'hFFFF));

        // list hits and their priority
        apply_rule(32'd0, 32'd0, MODE_ALL_LISTS, 5'd16, 5'd16, 5'd16);
        offer(header(32'd1, EP_WEB, {32'hFFFF_FFFF, 16'hFFFF}, CLASS_CONTENT));
        offer(header(32'd1, EP_WEB, {32'h1234_5678, 16'd9}, 6'h0));
        offer(header(32'd1, {32'h1234_5678, 16'd9}, EP_MDNS, 6'h0));
        offer(header(32'd1, {32'hFFFF_FFFF, 16'd9}, {32'h1234_5678, 16'd9}, 6'h0));
        offer(header(32'd1, {32'h1234_5678, 16'hFFFF}, {32'h1234_5678, 16'd9}, 6'h0));
        offer(header(32'd1, {32'h1234_5678, 16'd9}, {32'h8765_4321, 16'd10}, 6'h3E));
        apply_rule(32'd0, 32'd0, 10'b00000_10010, 5'd16, 5'd0, 5'd0);
        offer(header(32'd1, EP_WEB, {32'h1234_5678, 16'd9}, 6'h0));
        offer(header(32'd1, EP_WEB, EP_MDNS, 6'h0));
        // last slot falls outside a count of fifteen
        apply_rule(32'd0, 32'd0, MODE_ALL_LISTS, 5'd15, 5'd15, 5'd15);
        offer(header(32'd1, {32'h1234_5678, 16'd9}, EP_MDNS, 6'h0));
        offer(header(32'd1, {32'hFFFF_FFFF, 16'hFFFF}, {32'h1234_5678, 16'd9}, 6'h0));
        // counts above the depth saturate
        apply_rule(32'd0, 32'd0, 10'h3FF, 5'd31, 5'd31, 5'd31);
        offer(header(32'd1, {32'h1234_5678, 16'd9}, EP_MDNS, 6'h0));
        offer(header(32'd1, {32'hFFFF_FFFF, 16'hFFFF}, EP_WEB, CLASS_CONTENT));

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(3))
                0: begin lo = 32'h0; hi = 32'h0; end
                1: begin lo = $urandom; hi = 32'h0; end
                2: begin lo = 32'h0; hi = $urandom; end
                default: begin lo = $urandom; hi = lo + $urandom_range(1000000); end
            endcase
            if ($urandom_range(9) < 2) begin
                mode = {5'($urandom), 5'b0};
            end else begin
                mode = 10'($urandom);
                if (mode[3:0] == 4'b0) mode[MODE_EPLIST] = 1'b1;
            end
            ep_n   = pick_count();
            addr_n = pick_count();
            port_n = pick_count();
            case (p)
                0: begin lo = 32'h0; hi = 32'h0; mode = 10'h3FF;
                         ep_n = 5'd16; addr_n = 5'd16; port_n = 5'd16; end
                1: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; end
                2: begin mode = 10'h0; ep_n = 5'd0; addr_n = 5'd0; port_n = 5'd0; end
                3: begin lo = 32'd1; hi = 32'hFFFF_FFFF;
                         ep_n = 5'd31; addr_n = 5'd31; port_n = 5'd31; end
                default: ;
            endcase
            tx_idle_pct  = (p == 5) ? 0 : 21;
            rx_stall_pct = (p == 5) ? 0 : 21;
            apply_rule(lo, hi, mode, ep_n, addr_n, port_n);
            // receiver holds off while the sender keeps offering
            if (p == 7) hold_cycles = 400;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 9 && k == ITEMS_PER_PHASE / 2) drain();
                offer(random_item());
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (verdict_errors == 0 && verdicts_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
